// ----- rtl/base64_stream_encoder_defines.svh -----
// Assertion macros for the base64 stream encoder.
`ifndef BASE64_STREAM_ENCODER_DEFINES_SVH
`define BASE64_STREAM_ENCODER_DEFINES_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define B64E_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("b64e assertion failed");

// cond must never be true outside reset
`define B64E_ASSERT_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("b64e forbidden condition seen");

`else

`define B64E_ASSERT(lbl, clk, rst, prop)
`define B64E_ASSERT_NEVER(lbl, clk, rst, cond)

`endif

`endif

// ----- rtl/b64e_pkg.sv -----
`timescale 1ns / 1ps
package b64e_pkg;

   localparam int unsigned BYTE_W     = 8;
   localparam int unsigned SEXTET_W   = 6;
   localparam int unsigned LEFT_W     = 4;
   localparam int unsigned CHAR_SLOTS = 4;
   localparam int unsigned SLOT_W     = 2;
   localparam int unsigned CNT_W      = 16;
   localparam int unsigned JOB_DEPTH  = 4;
   localparam int unsigned JOB_PTR_W  = 2;
   localparam int unsigned JOB_CNT_W  = 3;
   localparam int unsigned ADDR_W     = 3;
   localparam int unsigned DATA_W     = 32;
   localparam int unsigned REG_IDX_W  = ADDR_W - 2;

   localparam logic [REG_IDX_W-1:0] REG_OUT_LIMIT   = '0;
   localparam logic [CNT_W-1:0]     OUT_LIMIT_RESET = 16'hFFFF;

   localparam logic [BYTE_W-1:0] CHAR_PAD     = 8'h3D;  // '='
   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_DIGIT_0 = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_PLUS    = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_SLASH   = 8'h2F;
   localparam logic [BYTE_W-1:0] CHAR_NONE    = 8'h00;

   // byte position inside a 3-byte group
   typedef enum logic [1:0] {
      GRP_FIRST  = 2'd0,
      GRP_SECOND = 2'd1,
      GRP_THIRD  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              last_byte;
   } req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] out_char;
      logic              overflow;
      logic              end_of_run;
   } rsp_type;

   // characters produced by one byte, slot 0 first
   typedef struct packed {
      logic [CHAR_SLOTS-1:0][BYTE_W-1:0] chars;
      logic [SLOT_W-1:0]                 last_slot;
      logic                              last_byte;
   } job_type;

   typedef struct packed {
      logic aborted;
      logic load;
   } bk_status_type;

   function automatic logic [BYTE_W-1:0] b64_char(input logic [SEXTET_W-1:0] v);
      logic [BYTE_W-1:0] vx;
      logic [BYTE_W-1:0] ch;
      vx = BYTE_W'(v);
      priority if (v < 6'd26) begin
         ch = CHAR_UPPER_A + vx;
      end else if (v < 6'd52) begin
         ch = CHAR_LOWER_A + vx - 8'd26;
      end else if (v < 6'd62) begin
         ch = CHAR_DIGIT_0 + vx - 8'd52;
      end else if (v == 6'd62) begin
         ch = CHAR_PLUS;
      end else begin
         ch = CHAR_SLASH;
      end
      return ch;
   endfunction

endpackage

// ----- rtl/b64e_front.sv -----
`timescale 1ns / 1ps
module b64e_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  b64e_pkg::req_type req_payload,
   input  logic              q_full,
   output logic              q_push,
   output b64e_pkg::job_type q_job
);
   import b64e_pkg::*;

   phase_type         phase_ff, phase_in;
   logic [LEFT_W-1:0] left_ff, left_in;
   logic [BYTE_W-1:0] b;
   logic              last;

   assign b      = req_payload.data_byte;
   assign last   = req_payload.last_byte;
   assign q_push = req_push && !q_full;

   always_comb begin
      q_job.chars     = {CHAR_SLOTS{CHAR_PAD}};
      q_job.last_slot = '0;
      q_job.last_byte = last;
      phase_in        = phase_ff;
      left_in         = left_ff;
      unique case (phase_ff)
         GRP_FIRST: begin
            q_job.chars[0] = b64_char(b[7:2]);
            q_job.chars[1] = b64_char({b[1:0], 4'b0000});
            if (last) begin
               q_job.last_slot = 2'd3;
            end
            phase_in = GRP_SECOND;
            left_in  = {2'b00, b[1:0]};
         end
         GRP_SECOND: begin
            q_job.chars[0] = b64_char({left_ff[1:0], b[7:4]});
            q_job.chars[1] = b64_char({b[3:0], 2'b00});
            if (last) begin
               q_job.last_slot = 2'd2;
            end
            phase_in = GRP_THIRD;
            left_in  = b[3:0];
         end
         default: begin
            // third byte, unused code handled the same way
            q_job.chars[0]  = b64_char({left_ff, b[7:6]});
            q_job.chars[1]  = b64_char(b[5:0]);
            q_job.last_slot = 2'd1;
            phase_in        = GRP_FIRST;
            left_in         = '0;
         end
      endcase
      if (last) begin
         phase_in = GRP_FIRST;
         left_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= GRP_FIRST;
         left_ff  <= '0;
      end else if (q_push) begin
         phase_ff <= phase_in;
         left_ff  <= left_in;
      end
   end

endmodule

// ----- rtl/b64e_queue.sv -----
`timescale 1ns / 1ps
module b64e_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  b64e_pkg::job_type push_job,
   input  logic              pop,
   output b64e_pkg::job_type pop_job,
   output logic              full,
   output logic              empty
);
   import b64e_pkg::*;

   job_type                slots_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [JOB_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [JOB_CNT_W-1:0]   count_ff, count_in;
   logic                   do_push, do_pop;

   assign full    = (count_ff == JOB_CNT_W'(JOB_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign pop_job = slots_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + JOB_CNT_W'(do_push) - JOB_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ----- rtl/b64e_back.sv -----
`timescale 1ns / 1ps
module b64e_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [15:0]             out_limit,
   input  logic                    q_empty,
   input  b64e_pkg::job_type       q_job,
   output logic                    q_pop,
   input  logic                    rsp_pop,
   output logic                    rsp_empty,
   output b64e_pkg::rsp_type       rsp_payload,
   output b64e_pkg::bk_status_type status
);
   import b64e_pkg::*;

   logic [SLOT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0]  written_ff, written_in;
   logic              aborted_ff, aborted_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;
   logic              step, have, fits, at_end, load;

   // output register free, or being emptied this cycle
   assign step   = !rsp_valid_ff || rsp_pop;
   assign have   = step && !q_empty;
   // one slot stays reserved for the terminator
   assign fits   = (({1'b0, written_ff} + 17'd1) < {1'b0, out_limit});
   assign at_end = (idx_ff == q_job.last_slot);

   always_comb begin
      idx_in     = idx_ff;
      written_in = written_ff;
      aborted_in = aborted_ff;
      rsp_in     = rsp_ff;
      q_pop      = 1'b0;
      load       = 1'b0;
      if (have) begin
         if (aborted_ff) begin
            // dropped byte
            q_pop  = 1'b1;
            idx_in = '0;
         end else begin
            load = 1'b1;
            if (fits) begin
               rsp_in.out_char   = q_job.chars[idx_ff];
               rsp_in.overflow   = 1'b0;
               rsp_in.end_of_run = q_job.last_byte && at_end;
               written_in        = written_ff + 1'b1;
               if (at_end) begin
                  q_pop  = 1'b1;
                  idx_in = '0;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end else begin
               rsp_in.out_char   = CHAR_NONE;
               rsp_in.overflow   = 1'b1;
               rsp_in.end_of_run = 1'b1;
               aborted_in        = 1'b1;
               q_pop             = 1'b1;
               idx_in            = '0;
            end
         end
         if (q_pop && q_job.last_byte) begin
            written_in = '0;
            aborted_in = 1'b0;
         end
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         written_ff   <= '0;
         aborted_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         written_ff   <= written_in;
         aborted_ff   <= aborted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_empty      = !rsp_valid_ff;
   assign rsp_payload    = rsp_ff;
   assign status.aborted = aborted_ff;
   assign status.load    = load;

endmodule

// ----- rtl/base64_stream_encoder.sv -----
`timescale 1ns / 1ps
// Channel   Dir   Handshake                    Payload
// req_      in    req_push / req_full          req_payload (data_byte, last_byte)
// rsp_      out   rsp_pop / rsp_empty          rsp_payload (out_char, overflow, end_of_run)
// csr_      in    APB psel/penable/pwrite      out_limit at byte address 0
//
// A byte is taken whenever the 4-deep job queue has room; the
// front turns it into its 1 to 4 characters at once.
// The back emits one character per cycle while rsp_pop keeps taking results, so a
// byte yields one character (first or second of a group), two (third) or three to
// four (final byte with pads); a byte dropped after an overflow gives no output.
// Synchronous reset clears phase, counts and queue; out_limit returns to 65535.
// Stalls on rsp_ fill the job queue before req_full rises.
module base64_stream_encoder (
   input  logic                                clock,
   input  logic                                reset,
   // input queue side
   input  logic                                req_push,
   input  b64e_pkg::req_type                   req_payload,
   output logic                                req_full,
   // result queue side
   input  logic                                rsp_pop,
   output b64e_pkg::rsp_type                   rsp_payload,
   output logic                                rsp_empty,
   // register port
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [b64e_pkg::ADDR_W-1:0]         csr_paddr,
   input  logic [b64e_pkg::DATA_W-1:0]         csr_pwdata,
   output logic [b64e_pkg::DATA_W-1:0]         csr_prdata,
   output logic                                csr_pready
);
   import b64e_pkg::*;

`include "base64_stream_encoder_defines.svh"

   logic [CNT_W-1:0] out_limit_ff, out_limit_in;
   logic             csr_wr;
   logic             reg_hit;

   logic             q_push, q_pop, q_full, q_empty;
   job_type          fr_job, bk_job;
   bk_status_type    bk_status;

   logic             rsp_err;
   logic             rsp_err_shape_ok;

   // ---------------------------------------------------------------
   // register port: zero wait states, word index taken from paddr[2]
   // ---------------------------------------------------------------
   assign csr_pready = 1'b1;
   assign reg_hit    = (csr_paddr[ADDR_W-1:2] == REG_OUT_LIMIT);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = reg_hit ? DATA_W'(out_limit_ff) : '0;

   always_comb begin
      out_limit_in = out_limit_ff;
      if (csr_wr && reg_hit) begin
         out_limit_in = csr_pwdata[CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_limit_ff <= OUT_LIMIT_RESET;
      end else begin
         out_limit_ff <= out_limit_in;
      end
   end

   // ---------------------------------------------------------------
   // front: group phase tracking and alphabet lookup per byte
   // ---------------------------------------------------------------
   assign req_full = q_full;

   b64e_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_payload (req_payload),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (fr_job)
   );

   // job queue decouples byte intake from character output
   b64e_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (fr_job),
      .pop      (q_pop),
      .pop_job  (bk_job),
      .full     (q_full),
      .empty    (q_empty)
   );

   // ---------------------------------------------------------------
   // back: limit check, overflow abort, one character per transaction
   // ---------------------------------------------------------------
   b64e_back u_back (
      .clock       (clock),
      .reset       (reset),
      .out_limit   (out_limit_ff),
      .q_empty     (q_empty),
      .q_job       (bk_job),
      .q_pop       (q_pop),
      .rsp_pop     (rsp_pop),
      .rsp_empty   (rsp_empty),
      .rsp_payload (rsp_payload),
      .status      (bk_status)
   );

   // ---------------------------------------------------------------
   // checks
   // ---------------------------------------------------------------
   assign rsp_err          = !rsp_empty && rsp_payload.overflow;
   assign rsp_err_shape_ok = rsp_payload.end_of_run && (rsp_payload.out_char == CHAR_NONE);

   // an accepted byte leaves the queue non-empty on the next cycle
   `B64E_ASSERT(a_push_lands, clock, reset, q_push |=> !q_empty)
   // nothing is loaded for output while the message is aborted
   `B64E_ASSERT_NEVER(a_no_load_aborted, clock, reset, bk_status.aborted && bk_status.load)
   // an error result always closes its run and carries no character
   `B64E_ASSERT(a_err_shape, clock, reset, rsp_err |-> rsp_err_shape_ok)

endmodule

// ----- bench/base64_stream_encoder_tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for base64_stream_encoder: a transaction-level model of
// the encoder runs alongside the block and queues the characters it should
// produce; every popped result is compared against the oldest queued one.
module base64_stream_encoder_tb;
   import b64e_pkg::*;

   localparam int STALL_LIMIT   = 2000;  // cycles with no transaction at all
   localparam int SETTLE_CYCLES = 12;    // job queue + output register, dropped bytes

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_push = 1'b0;
   req_type             req_payload = '0;
   logic                req_full;
   logic                rsp_pop = 1'b0;
   rsp_type             rsp_payload;
   logic                rsp_empty;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [ADDR_W-1:0]   csr_paddr = '0;
   logic [DATA_W-1:0]   csr_pwdata = '0;
   logic [DATA_W-1:0]   csr_prdata;
   logic                csr_pready;

   // model state: mirrors what the encoder must keep between bytes
   logic [1:0]          grp_phase = GRP_FIRST;
   logic [LEFT_W-1:0]   grp_left = '0;
   logic [CNT_W-1:0]    chars_done = '0;
   logic                msg_aborted = 1'b0;
   logic [CNT_W-1:0]    char_limit = OUT_LIMIT_RESET;

   rsp_type             expected_chars[$];
   int                  fail_count = 0;
   int                  stall_cycles = 0;
   int unsigned         send_idle_pct = 30;
   int unsigned         recv_idle_pct = 47;

   base64_stream_encoder DUT (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_payload (req_payload),
      .req_full    (req_full),
      .rsp_pop     (rsp_pop),
      .rsp_payload (rsp_payload),
      .rsp_empty   (rsp_empty),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Encoder model
   // ------------------------------------------------------------------

   function automatic logic [7:0] sextet_char(input logic [SEXTET_W-1:0] v);
      string alpha;
      alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
      return alpha[v];
   endfunction

   // One output slot. The terminator slot means at most char_limit - 1
   // characters fit; the first one that does not fit becomes the error
   // result and the rest of the message is dropped.
   function automatic void emit_char(input logic [7:0] ch);
      rsp_type r;
      if (msg_aborted) return;
      if (int'(chars_done) + 1 < int'(char_limit)) begin
         r.out_char   = ch;
         r.overflow   = 1'b0;
         r.end_of_run = 1'b0;
         chars_done   = chars_done + 1'b1;
      end else begin
         r.out_char   = CHAR_NONE;
         r.overflow   = 1'b1;
         r.end_of_run = 1'b1;
         msg_aborted  = 1'b1;
      end
      expected_chars.push_back(r);
   endfunction

   function automatic void encode_byte(input logic [7:0] b, input logic fin);
      int      queued;
      rsp_type tail;
      queued = expected_chars.size();
      if (!msg_aborted) begin
         if (grp_phase == GRP_FIRST) begin
            emit_char(sextet_char(b[7:2]));
            grp_left  = {2'b00, b[1:0]};
            grp_phase = GRP_SECOND;
            if (fin) begin
               emit_char(sextet_char({b[1:0], 4'b0000}));
               emit_char(CHAR_PAD);
               emit_char(CHAR_PAD);
            end
         end else if (grp_phase == GRP_SECOND) begin
            emit_char(sextet_char({grp_left[1:0], b[7:4]}));
            grp_left  = b[3:0];
            grp_phase = GRP_THIRD;
            if (fin) begin
               emit_char(sextet_char({b[3:0], 2'b00}));
               emit_char(CHAR_PAD);
            end
         end else begin
            // third byte closes the group (phase 3 can't occur, same path)
            emit_char(sextet_char({grp_left, b[7:6]}));
            emit_char(sextet_char(b[5:0]));
            grp_left  = '0;
            grp_phase = GRP_FIRST;
         end
      end
      if (fin) begin
         // tag the last character of the message, if this byte made any
         if (expected_chars.size() > queued) begin
            tail = expected_chars.pop_back();
            tail.end_of_run = 1'b1;
            expected_chars.push_back(tail);
         end
         grp_phase   = GRP_FIRST;
         grp_left    = '0;
         chars_done  = '0;
         msg_aborted = 1'b0;
      end
   endfunction

   // ------------------------------------------------------------------
   // Stimulus helpers
   // ------------------------------------------------------------------

   // req_push is left high after a transaction so back-to-back bytes never
   // see it dropped and raised in one step; callers that stop sending
   // lower it through wait_idle.
   task automatic push_byte(input logic [7:0] d, input logic fin);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push    <= 1'b1;
      req_payload <= '{data_byte: d, last_byte: fin};
      do @(posedge clock); while (req_full);
      encode_byte(d, fin);
   endtask

   // Stop sending and wait for every queued character; with settle set,
   // also give dropped bytes time to leave the job queue.
   task automatic wait_idle(input bit settle);
      req_push <= 1'b0;
      @(posedge clock);
      while (expected_chars.size() != 0) @(posedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_out_limit(input logic [CNT_W-1:0] value);
      wait_idle(1'b1);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_OUT_LIMIT, 2'b00};
      csr_pwdata  <= DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      char_limit = value;
   endtask

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------

   // Every group position on the final byte, all-zero / all-one bytes,
   // and the '+' and '/' symbols, with the full-size limit.
   task automatic test_group_phases();
      write_out_limit(16'hFFFF);
      push_byte(8'h00, 1'b1);                              // AA==
      push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b1);      // //8=
      push_byte(8'h00, 1'b0); push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b1);                              // AAAA
      push_byte(8'hFB, 1'b0); push_byte(8'hEF, 1'b0);
      push_byte(8'hBE, 1'b1);                              // ++++
      push_byte(8'hFF, 1'b0); push_byte(8'hFF, 1'b0);
      push_byte(8'hFF, 1'b0); push_byte(8'h80, 1'b1);      // ////gA==
   endtask

   // Output limit edges: overrun on the first character, a zero limit,
   // overrun in the pads after good characters, an exact fit, and a
   // fresh message right after an aborted one.
   task automatic test_overrun();
      write_out_limit(16'd1);
      push_byte(8'h41, 1'b0); push_byte(8'h42, 1'b1);
      write_out_limit(16'd0);
      push_byte(8'hFF, 1'b1);
      write_out_limit(16'd3);
      push_byte(8'h00, 1'b1);
      write_out_limit(16'd5);
      push_byte(8'h5A, 1'b1);
      push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b1);
      write_out_limit(16'd2);
      push_byte(8'hAA, 1'b0); push_byte(8'hBB, 1'b0); push_byte(8'hCC, 1'b1);
   endtask

   // Sender goes quiet mid-message until the block has drained, then
   // finishes the message: leftover bits must survive the idle time.
   task automatic test_pause_midstream();
      write_out_limit(16'hFFFF);
      push_byte(8'($urandom_range(0, 255)), 1'b0);
      push_byte(8'($urandom_range(0, 255)), 1'b0);
      wait_idle(1'b0);
      push_byte(8'($urandom_range(0, 255)), 1'b0);
      push_byte(8'($urandom_range(0, 255)), 1'b1);
   endtask

   // Random messages of random length; the final byte of the phase always
   // ends a message so the limit can be changed cleanly afterwards.
   task automatic test_random_stream(input int unsigned send_pct, input int unsigned recv_pct,
                                     input logic [CNT_W-1:0] limit, input int n_bytes);
      write_out_limit(limit);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int i = 0; i < n_bytes; i++) begin
         push_byte(8'($urandom_range(0, 255)),
                   (i == n_bytes - 1) || ($urandom_range(0, 3) == 0));
      end
   endtask

   // ------------------------------------------------------------------
   // Receiver, checker, watchdog
   // ------------------------------------------------------------------

   always @(posedge clock) begin
      rsp_pop <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_chars.size() == 0) begin
            $error("result with nothing expected: out_char %h overflow %b end_of_run %b",
                   rsp_payload.out_char, rsp_payload.overflow, rsp_payload.end_of_run);
            fail_count++;
         end else begin
            want = expected_chars.pop_front();
            if (rsp_payload.out_char !== want.out_char) begin
               $error("out_char expected %h actual %h", want.out_char, rsp_payload.out_char);
               fail_count++;
            end
            if (rsp_payload.overflow !== want.overflow) begin
               $error("overflow expected %b actual %b", want.overflow, rsp_payload.overflow);
               fail_count++;
            end
            if (rsp_payload.end_of_run !== want.end_of_run) begin
               $error("end_of_run expected %b actual %b",
                      want.end_of_run, rsp_payload.end_of_run);
               fail_count++;
            end
         end
      end
   end

   // a hang on either side ends the run
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_group_phases();
      test_overrun();
      test_pause_midstream();
      test_random_stream(30, 47, 16'hFFFF, 32);
      test_random_stream(47, 30, 16'($urandom_range(2, 9)), 25);
      test_random_stream(0, 0, 16'($urandom_range(10, 24)), 25);

      wait_idle(1'b1);
      if (expected_chars.size() != 0) begin
         $error("%0d expected results never arrived", expected_chars.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
